// ----- rtl/core/black_region_outline_filter_unit_defines.svh -----
// Assertion macros shared by the outline filter checkers.
`ifndef BLACK_REGION_OUTLINE_FILTER_UNIT_DEFINES_SVH
`define BLACK_REGION_OUTLINE_FILTER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define BROF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("outline filter check failed");

// Next-cycle implication, disabled while reset is low.
`define BROF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("outline filter check failed");

`endif

// ----- rtl/core/brof_pkg.sv -----
// Types, codes and helpers shared by the outline filter modules.
`timescale 1ns / 1ps
package brof_pkg;

    localparam int IMG_W_BITS = 11;
    localparam int IMG_H_BITS = 12;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    localparam logic [IMG_W_BITS-1:0] IMAGE_WIDTH_RST  = 11'd640;
    localparam logic [IMG_H_BITS-1:0] IMAGE_HEIGHT_RST = 12'd480;

    typedef logic [23:0] t_rgb;
    typedef logic [1:0]  t_kind;

    localparam t_rgb WHITE_RGB = 24'hFF_FFFF;
    localparam t_rgb BLACK_RGB = 24'h00_0000;

    localparam t_kind KIND_TOP    = 2'd0;
    localparam t_kind KIND_BODY   = 2'd1;
    localparam t_kind KIND_FLUSH  = 2'd2;
    localparam t_kind KIND_BOTTOM = 2'd3;

    typedef struct packed {
        t_kind kind;
        logic  first;
        logic  last;
        logic  up_true;
        logic  img_end;
        t_rgb  pix;
    } t_item;

    function automatic logic rgb_is_zero(input t_rgb px);
        return px == BLACK_RGB;
    endfunction

endpackage

// ----- rtl/core/black_region_outline_filter_unit.sv -----
// Top level of the black region outline filter.
`timescale 1ns / 1ps
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one transaction per pixel in
//   raster order (i_mode = 0), then flush transactions (i_mode = 1) that drain
//   the last row and the bottom border. Output channel (o_out_valid /
//   i_out_ready) gives the bordered image in raster order; o_run_last marks the
//   last result of each input transaction, o_image_last the bottom-right pixel.
//   Configuration writes (i_cfg_we) set width and height and restart the image;
//   issue them only while the block is idle.
//   An accepted transaction passes the queue, the stage-two register and the
//   output register. Throughput: one transaction per cycle while the queue has
//   room; a transaction at a row start or end emits 2 or 3 results, bounded by
//   the single output register at one result per cycle. A 4-entry queue between
//   classification and filtering absorbs these bursts.
//   Reset: position counters clear, width returns to 640 and height to 480;
//   the line stores are not cleared and need no clearing pass.
//   Stall: while i_out_ready is low the output holds, the queue fills and
//   o_in_ready drops once it is full.
module black_region_outline_filter_unit #(
    parameter int MAX_WIDTH   = 1024,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [brof_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [brof_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_mode,
    input  logic [7:0]                      i_red_in,
    input  logic [7:0]                      i_green_in,
    input  logic [7:0]                      i_blue_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [7:0]                      o_red_out,
    output logic [7:0]                      o_green_out,
    output logic [7:0]                      o_blue_out,
    output logic                            o_run_last,
    output logic                            o_image_last
);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int QW = $bits(brof_pkg::t_item) + AW;

    logic            push;
    logic            full;
    brof_pkg::t_item f_item;
    logic [AW-1:0]   f_col;
    logic            q_valid;
    logic [QW-1:0]   q_data;
    logic            pop;
    brof_pkg::t_rgb  out_rgb;

    brof_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_pix       ({i_red_in, i_green_in, i_blue_in}),
        .i_full      (full),
        .o_push      (push),
        .o_item      (f_item),
        .o_col       (f_col)
    );

    brof_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_item, f_col}),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    brof_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_item     (q_data[QW-1:AW]),
        .i_q_col      (q_data[AW-1:0]),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_rgb        (out_rgb),
        .o_run_last   (o_run_last),
        .o_image_last (o_image_last)
    );

    assign o_red_out   = out_rgb[23:16];
    assign o_green_out = out_rgb[15:8];
    assign o_blue_out  = out_rgb[7:0];
endmodule

// ----- rtl/core/brof_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module brof_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/core/brof_front.sv -----
// Front end: configuration, position tracking and classification of transactions.
`timescale 1ns / 1ps
module brof_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [brof_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [brof_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_mode,
    input  brof_pkg::t_rgb                      i_pix,
    input  logic                                i_full,
    output logic                                o_push,
    output brof_pkg::t_item                     o_item,
    output logic [$clog2(MAX_WIDTH)-1:0]        o_col
);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int UW = $clog2(MAX_WIDTH + 1);
    localparam int HW = brof_pkg::IMG_H_BITS;

    logic [brof_pkg::IMG_W_BITS-1:0] r_img_w;
    logic [HW-1:0]                   r_img_h;
    logic [AW-1:0]                   r_col;
    logic [HW-1:0]                   r_row;
    logic                            r_fphase;
    logic [AW-1:0]                   r_fcol;

    logic [UW-1:0] used_w;
    logic [HW-1:0] used_h;
    logic [AW-1:0] sel_col;
    logic          is_first;
    logic          is_last;
    logic          rows_done;
    logic          accept;
    logic          keep;

    always_comb begin
        if (r_img_w == '0) begin
            used_w = UW'(1);
        end else if (32'(r_img_w) > 32'(MAX_WIDTH)) begin
            used_w = UW'(MAX_WIDTH);
        end else begin
            used_w = UW'(r_img_w);
        end
    end

    assign used_h    = (r_img_h == '0) ? HW'(1) : r_img_h;
    assign sel_col   = i_mode ? r_fcol : r_col;
    assign is_first  = (sel_col == '0);
    assign is_last   = ((UW'(sel_col) + UW'(1)) == used_w);
    assign rows_done = (r_row >= used_h);

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && !i_full;
    assign keep       = i_mode ? rows_done : !rows_done;
    assign o_push     = accept && keep;
    assign o_col      = sel_col;

    always_comb begin
        o_item.first   = is_first;
        o_item.last    = is_last;
        o_item.pix     = i_pix;
        o_item.img_end = 1'b0;
        o_item.up_true = 1'b0;
        if (!i_mode) begin
            if (r_row == '0) begin
                o_item.kind = brof_pkg::KIND_TOP;
            end else begin
                o_item.kind    = brof_pkg::KIND_BODY;
                o_item.up_true = (r_row == HW'(1));
            end
        end else if (!r_fphase) begin
            o_item.kind    = brof_pkg::KIND_FLUSH;
            o_item.up_true = (used_h == HW'(1));
        end else begin
            o_item.kind    = brof_pkg::KIND_BOTTOM;
            o_item.img_end = is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w  <= brof_pkg::IMAGE_WIDTH_RST;
            r_img_h  <= brof_pkg::IMAGE_HEIGHT_RST;
            r_col    <= '0;
            r_row    <= '0;
            r_fphase <= 1'b0;
            r_fcol   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                brof_pkg::CFG_IMAGE_WIDTH: begin
                    r_img_w  <= i_cfg_data[brof_pkg::IMG_W_BITS-1:0];
                    r_col    <= '0;
                    r_row    <= '0;
                    r_fphase <= 1'b0;
                    r_fcol   <= '0;
                end
                brof_pkg::CFG_IMAGE_HEIGHT: begin
                    r_img_h  <= i_cfg_data[HW-1:0];
                    r_col    <= '0;
                    r_row    <= '0;
                    r_fphase <= 1'b0;
                    r_fcol   <= '0;
                end
                default: begin
                end
            endcase
        end else if (o_push) begin
            if (!i_mode) begin
                if (is_last) begin
                    r_col <= '0;
                    r_row <= r_row + HW'(1);
                end else begin
                    r_col <= r_col + AW'(1);
                end
            end else if (!r_fphase) begin
                if (is_last) begin
                    r_fphase <= 1'b1;
                    r_fcol   <= '0;
                end else begin
                    r_fcol <= r_fcol + AW'(1);
                end
            end else if (is_last) begin
                r_col    <= '0;
                r_row    <= '0;
                r_fphase <= 1'b0;
                r_fcol   <= '0;
            end else begin
                r_fcol <= r_fcol + AW'(1);
            end
        end
    end
endmodule

// ----- rtl/core/brof_fifo.sv -----
// Small register queue between front end and back end.
`timescale 1ns / 1ps
module brof_fifo #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr;
    logic [PW-1:0]    r_rptr;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end
endmodule

// ----- rtl/core/brof_back.sv -----
// Back end: line stores, neighbour filter and result sequencing.
`timescale 1ns / 1ps
module brof_back #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    input  brof_pkg::t_item              i_q_item,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_q_col,
    output logic                         o_pop,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output brof_pkg::t_rgb               o_rgb,
    output logic                         o_run_last,
    output logic                         o_image_last
);
    localparam int AW = $clog2(MAX_WIDTH);

    localparam logic [1:0] P_LEFT  = 2'd0;
    localparam logic [1:0] P_MAIN  = 2'd1;
    localparam logic [1:0] P_RIGHT = 2'd2;

    logic            r_s2_valid;
    brof_pkg::t_item r_s2;
    logic [AW-1:0]   r_s2_col;
    logic [1:0]      r_part;
    logic            r_fwd_self;
    logic            r_fwd_right;
    logic            r_fwd_up;
    brof_pkg::t_rgb  r_fwd_pix;
    logic            r_fwd_blk;
    logic            r_left_blk;
    logic            r_o_valid;
    brof_pkg::t_rgb  r_o_rgb;
    logic            r_o_run_last;
    logic            r_o_image_last;

    brof_pkg::t_rgb prev_q_self;
    brof_pkg::t_rgb prev_q_right;
    logic           older_q;
    brof_pkg::t_rgb self_pix;
    brof_pkg::t_rgb right_pix;
    logic           self_blk;
    logic           up_f;
    logic           down_f;
    logic           left_f;
    logic           right_f;
    logic [2:0]     nb_count;
    logic           is_filtered;
    brof_pkg::t_rgb main_rgb;
    brof_pkg::t_rgb cur_rgb;
    logic           final_part;
    logic           out_load;
    logic           s2_done;
    logic           load;
    logic           prev_we;
    logic           older_we;
    logic [AW-1:0]  right_addr;

    assign out_load = r_s2_valid && (!r_o_valid || i_out_ready);
    assign final_part = (r_part == P_RIGHT) || ((r_part == P_MAIN) && !r_s2.last);
    assign s2_done  = out_load && final_part;
    assign load     = i_q_valid && (!r_s2_valid || s2_done);
    assign o_pop    = load;

    assign is_filtered = (r_s2.kind == brof_pkg::KIND_BODY) ||
                         (r_s2.kind == brof_pkg::KIND_FLUSH);
    assign prev_we  = s2_done && ((r_s2.kind == brof_pkg::KIND_TOP) ||
                                  (r_s2.kind == brof_pkg::KIND_BODY));
    assign older_we = s2_done && (r_s2.kind == brof_pkg::KIND_BODY);
    assign right_addr = i_q_col + AW'(1);

    brof_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_prev_self (
        .i_clk   (i_clk),
        .i_we    (prev_we),
        .i_waddr (r_s2_col),
        .i_wdata (r_s2.pix),
        .i_re    (load),
        .i_raddr (i_q_col),
        .o_rdata (prev_q_self)
    );

    brof_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_prev_right (
        .i_clk   (i_clk),
        .i_we    (prev_we),
        .i_waddr (r_s2_col),
        .i_wdata (r_s2.pix),
        .i_re    (load),
        .i_raddr (right_addr),
        .o_rdata (prev_q_right)
    );

    brof_ram #(.WIDTH(1), .DEPTH(MAX_WIDTH)) u_older (
        .i_clk   (i_clk),
        .i_we    (older_we),
        .i_waddr (r_s2_col),
        .i_wdata (self_blk),
        .i_re    (load),
        .i_raddr (i_q_col),
        .o_rdata (older_q)
    );

    assign self_pix  = r_fwd_self ? r_fwd_pix : prev_q_self;
    assign right_pix = r_fwd_right ? r_fwd_pix : prev_q_right;
    assign self_blk  = brof_pkg::rgb_is_zero(self_pix);
    assign up_f      = r_s2.up_true || (r_fwd_up ? r_fwd_blk : older_q);
    assign down_f    = (r_s2.kind == brof_pkg::KIND_FLUSH) || brof_pkg::rgb_is_zero(r_s2.pix);
    assign left_f    = r_s2.first || r_left_blk;
    assign right_f   = r_s2.last || brof_pkg::rgb_is_zero(right_pix);
    assign nb_count  = 3'(up_f) + 3'(down_f) + 3'(left_f) + 3'(right_f);

    always_comb begin
        if (!is_filtered) begin
            main_rgb = brof_pkg::WHITE_RGB;
        end else if (!self_blk) begin
            main_rgb = self_pix;
        end else if ((nb_count == 3'd2) || (nb_count == 3'd3)) begin
            main_rgb = brof_pkg::BLACK_RGB;
        end else begin
            main_rgb = brof_pkg::WHITE_RGB;
        end
    end

    assign cur_rgb = (r_part == P_MAIN) ? main_rgb : brof_pkg::WHITE_RGB;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_s2        <= i_q_item;
            r_s2_col    <= i_q_col;
            r_fwd_self  <= prev_we && (r_s2_col == i_q_col);
            r_fwd_right <= prev_we && (r_s2_col == right_addr);
            r_fwd_up    <= older_we && (r_s2_col == i_q_col);
            r_fwd_pix   <= r_s2.pix;
            r_fwd_blk   <= self_blk;
        end
        if (s2_done && is_filtered) begin
            r_left_blk <= self_blk;
        end
        if (out_load) begin
            r_o_rgb        <= cur_rgb;
            r_o_run_last   <= final_part;
            r_o_image_last <= final_part && r_s2.img_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_part     <= P_LEFT;
            r_o_valid  <= 1'b0;
        end else begin
            if (load) begin
                r_s2_valid <= 1'b1;
                r_part     <= i_q_item.first ? P_LEFT : P_MAIN;
            end else if (s2_done) begin
                r_s2_valid <= 1'b0;
            end else if (out_load) begin
                case (r_part)
                    P_LEFT:  r_part <= P_MAIN;
                    P_MAIN:  r_part <= P_RIGHT;
                    default: r_part <= P_RIGHT;
                endcase
            end
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_rgb        = r_o_rgb;
    assign o_run_last   = r_o_run_last;
    assign o_image_last = r_o_image_last;
endmodule

// ----- rtl/core/brof_checker.sv -----
// Port-level checks for the outline filter, bound to the top level.
`timescale 1ns / 1ps
`include "black_region_outline_filter_unit_defines.svh"
module brof_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_red_out,
    input logic [7:0] o_green_out,
    input logic [7:0] o_blue_out,
    input logic       o_run_last,
    input logic       o_image_last
);
    `BROF_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_red_out) && $stable(o_green_out) && $stable(o_blue_out) && $stable(o_run_last) && $stable(o_image_last))
    `BROF_ASSERT_IMP(a_image_last_ends_run, i_clk, i_rst_n, o_out_valid && o_image_last, o_run_last)
    `BROF_ASSERT_IMP(a_image_last_white, i_clk, i_rst_n, o_out_valid && o_image_last, (o_red_out == 8'hFF) && (o_green_out == 8'hFF) && (o_blue_out == 8'hFF))
    `BROF_ASSERT_NXT(a_burst_no_gap, i_clk, i_rst_n, o_out_valid && i_out_ready && !o_run_last, o_out_valid)
endmodule

bind black_region_outline_filter_unit brof_checker u_brof_checker (.*);
